// ===== rtl/core/mer_pkg.sv =====
package mer_pkg;

  localparam int COMMAND_BITS = 13;
  localparam int DATA_BITS    = 16;
  localparam int ADDR_W       = 10;
  localparam int TICK_W       = 16;
  localparam int WORD_W       = 16;
  localparam int CMD_W        = 16;
  localparam int BIT_W        = 4;
  localparam int SUB_W        = 2;

  localparam logic [CMD_W-1:0] READ_OPCODE  = 16'h0180;
  localparam int               OPCODE_SHIFT = 4;

  // sub-phases of one serial bit
  localparam logic [SUB_W-1:0] SUB_FIRST  = 2'd0;
  localparam logic [SUB_W-1:0] SUB_SECOND = 2'd1;
  localparam logic [SUB_W-1:0] SUB_THIRD  = 2'd2;

  typedef enum logic [2:0] {
    SEG_IDLE,
    SEG_SEL,
    SEG_CMD,
    SEG_DATA,
    SEG_DESEL
  } seg_e;

  typedef struct packed {
    logic cs;
    logic clk;
    logic di;
    logic busy;
    logic valid;
  } pins_t;

endpackage

// ===== rtl/core/mer_seq.sv =====
module mer_seq (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        step_i,
  input  logic                        start_i,
  input  logic [mer_pkg::ADDR_W-1:0]  addr_i,
  input  logic                        dout_i,
  input  logic [mer_pkg::TICK_W-1:0]  ticks_i,
  output mer_pkg::pins_t              pins_o,
  output logic [mer_pkg::WORD_W-1:0]  word_o
);

  mer_pkg::seg_e                    seg_q, seg_d, eff_seg;
  logic [mer_pkg::TICK_W-1:0]       hold_q, hold_d, eff_hold, ticks_eff;
  logic [mer_pkg::SUB_W-1:0]        sub_q, sub_d, eff_sub;
  logic [mer_pkg::BIT_W-1:0]        bit_q, bit_d, eff_bit, cmd_idx;
  logic [mer_pkg::WORD_W-1:0]       shift_q, shift_d, eff_shift;
  logic [mer_pkg::ADDR_W-1:0]       addr_q, addr_d, eff_addr;
  logic [mer_pkg::CMD_W-1:0]        cmd_word;
  logic [mer_pkg::TICK_W:0]         hold_inc;
  logic                             start, done, sample, last_bit;
  mer_pkg::pins_t                   pins;

  always_comb begin
    start     = (seg_q == mer_pkg::SEG_IDLE) && start_i;
    eff_seg   = start ? mer_pkg::SEG_SEL : seg_q;
    eff_hold  = start ? '0 : hold_q;
    eff_sub   = start ? mer_pkg::SUB_FIRST : sub_q;
    eff_bit   = start ? '0 : bit_q;
    eff_shift = start ? '0 : shift_q;
    eff_addr  = start ? addr_i : addr_q;

    ticks_eff = (ticks_i == '0) ? mer_pkg::TICK_W'(1) : ticks_i;
    hold_inc  = {1'b0, eff_hold} + (mer_pkg::TICK_W+1)'(1);
    done      = hold_inc >= {1'b0, ticks_eff};

    cmd_word  = (mer_pkg::READ_OPCODE << mer_pkg::OPCODE_SHIFT)
              | mer_pkg::CMD_W'(eff_addr);
    cmd_idx   = mer_pkg::BIT_W'(mer_pkg::COMMAND_BITS - 1) - eff_bit;

    pins      = '0;
    sample    = 1'b0;
    last_bit  = 1'b0;
    seg_d     = eff_seg;
    sub_d     = eff_sub;
    bit_d     = eff_bit;
    addr_d    = eff_addr;
    shift_d   = eff_shift;
    hold_d    = done ? '0 : hold_inc[mer_pkg::TICK_W-1:0];

    unique case (eff_seg)
      mer_pkg::SEG_IDLE: begin
        hold_d = hold_q;
      end
      mer_pkg::SEG_SEL: begin
        pins.cs   = 1'b1;
        pins.busy = 1'b1;
        if (done) begin
          seg_d = mer_pkg::SEG_CMD;
          sub_d = mer_pkg::SUB_FIRST;
          bit_d = '0;
        end
      end
      mer_pkg::SEG_CMD: begin
        pins.cs   = 1'b1;
        pins.busy = 1'b1;
        pins.di   = cmd_word[cmd_idx];
        pins.clk  = eff_sub == mer_pkg::SUB_THIRD;
        last_bit  = eff_bit == mer_pkg::BIT_W'(mer_pkg::COMMAND_BITS - 1);
        if (done) begin
          if (eff_sub == mer_pkg::SUB_THIRD) begin
            sub_d = mer_pkg::SUB_FIRST;
            if (last_bit) begin
              seg_d = mer_pkg::SEG_DATA;
              bit_d = '0;
            end else begin
              bit_d = eff_bit + mer_pkg::BIT_W'(1);
            end
          end else begin
            sub_d = eff_sub + mer_pkg::SUB_W'(1);
          end
        end
      end
      mer_pkg::SEG_DATA: begin
        pins.cs   = 1'b1;
        pins.busy = 1'b1;
        pins.di   = eff_addr[0];
        pins.clk  = eff_sub != mer_pkg::SUB_FIRST;
        sample    = eff_sub == mer_pkg::SUB_SECOND;
        last_bit  = eff_bit == mer_pkg::BIT_W'(mer_pkg::DATA_BITS - 1);
        if (done) begin
          if (sample) begin
            shift_d = {eff_shift[mer_pkg::WORD_W-2:0], dout_i};
          end
          if (eff_sub == mer_pkg::SUB_THIRD) begin
            sub_d = mer_pkg::SUB_FIRST;
            if (last_bit) begin
              seg_d = mer_pkg::SEG_DESEL;
              bit_d = '0;
            end else begin
              bit_d = eff_bit + mer_pkg::BIT_W'(1);
            end
          end else begin
            sub_d = eff_sub + mer_pkg::SUB_W'(1);
          end
        end
      end
      mer_pkg::SEG_DESEL: begin
        pins.busy = 1'b1;
        if (done) begin
          pins.valid = 1'b1;
          seg_d      = mer_pkg::SEG_IDLE;
        end
      end
      default: begin
        seg_d = mer_pkg::SEG_IDLE;
      end
    endcase

    pins_o = pins;
    word_o = shift_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seg_q   <= mer_pkg::SEG_IDLE;
      hold_q  <= '0;
      sub_q   <= mer_pkg::SUB_FIRST;
      bit_q   <= '0;
      shift_q <= '0;
      addr_q  <= '0;
    end else if (step_i) begin
      seg_q   <= seg_d;
      hold_q  <= hold_d;
      sub_q   <= sub_d;
      bit_q   <= bit_d;
      shift_q <= shift_d;
      addr_q  <= addr_d;
    end
  end

  a_sub_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sub_q != 2'd3)
    else $error("sub-phase counter out of range");

endmodule

// ===== rtl/core/microwire_eeprom_word_reader.sv =====
// channel   | handshake                    | payload
// ----------+------------------------------+---------------------------------------------
// input     | in_valid_i / in_ready_o      | operation_i, word_address_i, data_out_pin_i
// result    | out_valid_o / out_ready_i    | chip_select_o .. read_word_o
// config    | cfg_we_i (no wait)           | cfg_wdata_i (phase_ticks)
//
// one transfer per clock while in_ready_o; result registered at that edge, offered next cycle
// the sequencer state and the pin decode sit between the input port and the result register
// input is taken whenever the result register is empty or being drained in the same cycle
// a stalled result holds the input side only, no state advances without a transfer
// reset (async, active low) clears the sequencer to idle and phase_ticks to 1
module microwire_eeprom_word_reader (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // configuration
  input  logic                        cfg_we_i,
  input  logic [mer_pkg::TICK_W-1:0]  cfg_wdata_i,
  // input channel
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        operation_i,
  input  logic [mer_pkg::ADDR_W-1:0]  word_address_i,
  input  logic                        data_out_pin_i,
  // result channel
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        chip_select_o,
  output logic                        serial_clock_o,
  output logic                        data_in_pin_o,
  output logic                        busy_res_o,
  output logic                        word_valid_o,
  output logic [mer_pkg::WORD_W-1:0]  read_word_o
);

  logic [mer_pkg::TICK_W-1:0] ticks_q;
  logic                       out_valid_q;
  mer_pkg::pins_t             pins, pins_q;
  logic [mer_pkg::WORD_W-1:0] word, word_q;
  logic                       in_xfer;

  // result register frees up when its content is taken this cycle
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_xfer    = in_valid_i && in_ready_o;

  // phase length register; a write takes effect once it is registered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ticks_q <= mer_pkg::TICK_W'(1);
    end else if (cfg_we_i) begin
      ticks_q <= cfg_wdata_i;
    end
  end

  // pin sequencer, advances one tick per input transfer
  mer_seq u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (in_xfer),
    .start_i (operation_i),
    .addr_i  (word_address_i),
    .dout_i  (data_out_pin_i),
    .ticks_i (ticks_q),
    .pins_o  (pins),
    .word_o  (word)
  );

  // result valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_xfer) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      pins_q <= pins;
      word_q <= word;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign chip_select_o  = pins_q.cs;
  assign serial_clock_o = pins_q.clk;
  assign data_in_pin_o  = pins_q.di;
  assign busy_res_o     = pins_q.busy;
  assign word_valid_o   = pins_q.valid;
  assign read_word_o    = word_q;

  // completion only happens in the deselect phase
  a_valid_desel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && pins_q.valid |-> pins_q.busy && !pins_q.cs)
    else $error("word_valid outside the deselect phase");

  // idle ticks drive all pins low
  a_idle_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !pins_q.busy |-> !pins_q.cs && !pins_q.clk && !pins_q.di && !pins_q.valid)
    else $error("pin activity on an idle tick");

  // clock only toggles while selected
  a_clk_selected: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && pins_q.clk |-> pins_q.cs)
    else $error("serial clock high without chip select");

endmodule
